// ----- rtl/mk3_pkg.sv -----
// ----------------------------------------------------------------------------
// mk3_pkg
// Shared types, constants and multiply helpers for the keystream decryptor.
// ----------------------------------------------------------------------------
package mk3_pkg;

  localparam int NUM_STAGES = 16;

  localparam logic [63:0] MIX_C1  = 64'h87c37b91114253d5;
  localparam logic [63:0] MIX_C2  = 64'h4cf5ad432745937f;
  localparam logic [63:0] FMIX_M1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_M2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] ADD_K1  = 64'h0000000052dce729;
  localparam logic [63:0] ADD_K2  = 64'h0000000038495ab5;
  localparam logic [63:0] MSG_LEN = 64'd16;

  localparam logic [31:0] RST_KEY_4_7   = 32'hF41CAB62;
  localparam logic [31:0] RST_KEY_8_11  = 32'hF376811C;
  localparam logic [31:0] RST_KEY_12_15 = 32'hD2A89E3E;
  localparam logic [31:0] RST_SEED      = 32'd42;

  typedef enum logic [1:0] {
    CFG_KEY_4_7   = 2'd0,
    CFG_KEY_8_11  = 2'd1,
    CFG_KEY_12_15 = 2'd2,
    CFG_SEED      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] key_4_7;
    logic [31:0] key_8_11;
    logic [31:0] key_12_15;
    logic [31:0] seed;
  } cfg_t;

  typedef struct packed {
    logic [NUM_STAGES:0] en;
  } lane_ctl_t;

  typedef struct packed {
    logic [63:0] h1;
    logic [63:0] h2;
    logic [63:0] w0;
    logic [63:0] w1;
  } lane_out_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [31:0] mid_a;
    logic [31:0] mid_b;
  } pp_t;

  // 64x64 -> low 64 product, split into 32x32 partial products
  function automatic pp_t mul_pp(input logic [63:0] x, input logic [63:0] c);
    pp_t         p;
    logic [31:0] xl;
    logic [31:0] xh;
    logic [31:0] cl;
    logic [31:0] ch;
    xl      = x[31:0];
    xh      = x[63:32];
    cl      = c[31:0];
    ch      = c[63:32];
    p.lo    = {32'h0, xl} * {32'h0, cl};
    p.mid_a = xl * ch;
    p.mid_b = xh * cl;
    return p;
  endfunction

  function automatic logic [63:0] mul_sum(input pp_t p);
    logic [31:0] mid;
    mid = p.mid_a + p.mid_b;
    return p.lo + {mid, 32'h0};
  endfunction

  function automatic logic [63:0] xs33(input logic [63:0] v);
    return v ^ {33'h0, v[63:33]};
  endfunction

endpackage

// ----- rtl/murmur3_keystream_xor_decrypt.sv -----
// ----------------------------------------------------------------------------
// murmur3_keystream_xor_decrypt
// Decrypts a 32-byte block by XOR with two 128-bit key digests.
//
// Input beat: two 32-bit keys and four 64-bit cipher words, taken when
// in_valid is high and in_stall is low. Output beat: four 64-bit plain
// words, taken when out_valid is high and out_stall is low.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0..2 fixed key bytes 4-15, 3 hash seed); write only while idle.
// Two digest lanes run side by side, one per key, each a 16-stage
// pipeline of 32x32 partial-product multipliers; a merge stage XORs the
// digests into the words and holds the output register.
// Each beat passes through the 16 lane stages and then the merge stage,
// whose register drives out_valid. Throughput: one beat per cycle while
// the output is not stalled, set by the fully pipelined lanes.
// Reset: all stages empty, configuration back to its default values.
// Output stall: the output beat holds; empty stages ahead still fill,
// and in_stall rises only once every stage holds a beat.
// ----------------------------------------------------------------------------
module murmur3_keystream_xor_decrypt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_first_key,
  input  logic [31:0] in_second_key,
  input  logic [63:0] in_cipher_word_0,
  input  logic [63:0] in_cipher_word_1,
  input  logic [63:0] in_cipher_word_2,
  input  logic [63:0] in_cipher_word_3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_plain_word_0,
  output logic [63:0] out_plain_word_1,
  output logic [63:0] out_plain_word_2,
  output logic [63:0] out_plain_word_3
);
  import mk3_pkg::*;

  cfg_t      cfg_r;
  lane_ctl_t ctl;
  lane_out_t lane_a;
  lane_out_t lane_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_4_7   <= RST_KEY_4_7;
      cfg_r.key_8_11  <= RST_KEY_8_11;
      cfg_r.key_12_15 <= RST_KEY_12_15;
      cfg_r.seed      <= RST_SEED;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KEY_4_7:   cfg_r.key_4_7   <= cfg_data;
        CFG_KEY_8_11:  cfg_r.key_8_11  <= cfg_data;
        CFG_KEY_12_15: cfg_r.key_12_15 <= cfg_data;
        CFG_SEED:      cfg_r.seed      <= cfg_data;
        default: ;
      endcase
    end
  end

  mk3_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  mk3_lane u_lane_a (
    .clk    (clk),
    .ctl    (ctl),
    .cfg    (cfg_r),
    .key    (in_first_key),
    .word_0 (in_cipher_word_0),
    .word_1 (in_cipher_word_1),
    .res    (lane_a)
  );

  mk3_lane u_lane_b (
    .clk    (clk),
    .ctl    (ctl),
    .cfg    (cfg_r),
    .key    (in_second_key),
    .word_0 (in_cipher_word_2),
    .word_1 (in_cipher_word_3),
    .res    (lane_b)
  );

  mk3_merge u_merge (
    .clk          (clk),
    .ctl          (ctl),
    .lane_a       (lane_a),
    .lane_b       (lane_b),
    .plain_word_0 (out_plain_word_0),
    .plain_word_1 (out_plain_word_1),
    .plain_word_2 (out_plain_word_2),
    .plain_word_3 (out_plain_word_3)
  );

endmodule

// ----- rtl/mk3_pipe_ctl.sv -----
// ----------------------------------------------------------------------------
// mk3_pipe_ctl
// Valid chain and per-stage advance enables; bubbles collapse under stall.
// ----------------------------------------------------------------------------
module mk3_pipe_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output mk3_pkg::lane_ctl_t ctl
);
  import mk3_pkg::*;

  logic [NUM_STAGES:0] valid_r;
  logic [NUM_STAGES:0] en;

  always_comb begin
    en[NUM_STAGES] = ~valid_r[NUM_STAGES] | ~out_stall;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      en[i] = ~valid_r[i] | en[i + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int i = 1; i <= NUM_STAGES; i++) begin
        if (en[i]) begin
          valid_r[i] <= valid_r[i - 1];
        end
      end
    end
  end

  assign ctl.en    = en;
  assign in_stall  = ~en[0];
  assign out_valid = valid_r[NUM_STAGES];

endmodule

// ----- rtl/mk3_lane.sv -----
// ----------------------------------------------------------------------------
// mk3_lane
// One pipelined 128-bit digest core for a single key, carrying its two words.
// ----------------------------------------------------------------------------
module mk3_lane (
  input  logic               clk,
  input  mk3_pkg::lane_ctl_t ctl,
  input  mk3_pkg::cfg_t      cfg,
  input  logic [31:0]        key,
  input  logic [63:0]        word_0,
  input  logic [63:0]        word_1,
  output mk3_pkg::lane_out_t res
);
  import mk3_pkg::*;

  logic [63:0] w0_r [NUM_STAGES];
  logic [63:0] w1_r [NUM_STAGES];

  logic [63:0] seed;
  logic [63:0] a0;
  logic [63:0] b0;
  logic [63:0] a1_sum;
  logic [63:0] b1_sum;
  logic [63:0] t1_x;
  logic [63:0] u_x;

  pp_t         ppa0_r;
  pp_t         ppb0_r;
  logic [63:0] a1_r;
  logic [63:0] b1_r;
  pp_t         ppa2_r;
  pp_t         ppb2_r;
  logic [63:0] a3_r;
  logic [63:0] b3_r;
  logic [63:0] t4_r;
  logic [63:0] b4_r;
  logic [63:0] s5_r;
  logic [63:0] b5_r;
  logic [63:0] u6_r;
  logic [63:0] s6_r;
  logic [63:0] s7a_r;
  logic [63:0] s7b_r;
  logic [63:0] x8a_r;
  logic [63:0] x8b_r;
  logic [63:0] x9a_r;
  logic [63:0] x9b_r;
  pp_t         pp10a_r;
  pp_t         pp10b_r;
  logic [63:0] y11a_r;
  logic [63:0] y11b_r;
  pp_t         pp12a_r;
  pp_t         pp12b_r;
  logic [63:0] z13a_r;
  logic [63:0] z13b_r;
  logic [63:0] h14_r;
  logic [63:0] f14_r;
  logic [63:0] h15a_r;
  logic [63:0] h15b_r;

  assign seed   = {32'h0, cfg.seed};
  assign a0     = {cfg.key_4_7, key};
  assign b0     = {cfg.key_12_15, cfg.key_8_11};
  assign a1_sum = mul_sum(ppa0_r);
  assign b1_sum = mul_sum(ppb0_r);
  assign t1_x   = seed ^ a3_r;
  assign u_x    = seed ^ b5_r;

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      w0_r[0] <= word_0;
      w1_r[0] <= word_1;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (ctl.en[i]) begin
        w0_r[i] <= w0_r[i - 1];
        w1_r[i] <= w1_r[i - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      ppa0_r <= mul_pp(a0, MIX_C1);
      ppb0_r <= mul_pp(b0, MIX_C2);
    end
    if (ctl.en[1]) begin
      a1_r <= {a1_sum[32:0], a1_sum[63:33]};
      b1_r <= {b1_sum[30:0], b1_sum[63:31]};
    end
    if (ctl.en[2]) begin
      ppa2_r <= mul_pp(a1_r, MIX_C2);
      ppb2_r <= mul_pp(b1_r, MIX_C1);
    end
    if (ctl.en[3]) begin
      a3_r <= mul_sum(ppa2_r);
      b3_r <= mul_sum(ppb2_r);
    end
    if (ctl.en[4]) begin
      t4_r <= {t1_x[36:0], t1_x[63:37]} + seed;
      b4_r <= b3_r;
    end
    if (ctl.en[5]) begin
      s5_r <= {t4_r[61:0], 2'b00} + t4_r + ADD_K1;
      b5_r <= b4_r;
    end
    if (ctl.en[6]) begin
      u6_r <= {u_x[32:0], u_x[63:33]} + s5_r;
      s6_r <= s5_r;
    end
    if (ctl.en[7]) begin
      s7a_r <= s6_r ^ MSG_LEN;
      s7b_r <= ({u6_r[61:0], 2'b00} + u6_r + ADD_K2) ^ MSG_LEN;
    end
    if (ctl.en[8]) begin
      x8a_r <= s7a_r + s7b_r;
      x8b_r <= s7b_r;
    end
    if (ctl.en[9]) begin
      x9a_r <= x8a_r;
      x9b_r <= x8b_r + x8a_r;
    end
    if (ctl.en[10]) begin
      pp10a_r <= mul_pp(xs33(x9a_r), FMIX_M1);
      pp10b_r <= mul_pp(xs33(x9b_r), FMIX_M1);
    end
    if (ctl.en[11]) begin
      y11a_r <= mul_sum(pp10a_r);
      y11b_r <= mul_sum(pp10b_r);
    end
    if (ctl.en[12]) begin
      pp12a_r <= mul_pp(xs33(y11a_r), FMIX_M2);
      pp12b_r <= mul_pp(xs33(y11b_r), FMIX_M2);
    end
    if (ctl.en[13]) begin
      z13a_r <= mul_sum(pp12a_r);
      z13b_r <= mul_sum(pp12b_r);
    end
    if (ctl.en[14]) begin
      h14_r <= xs33(z13a_r) + xs33(z13b_r);
      f14_r <= xs33(z13b_r);
    end
    if (ctl.en[15]) begin
      h15a_r <= h14_r;
      h15b_r <= f14_r + h14_r;
    end
  end

  assign res.h1 = h15a_r;
  assign res.h2 = h15b_r;
  assign res.w0 = w0_r[NUM_STAGES - 1];
  assign res.w1 = w1_r[NUM_STAGES - 1];

endmodule

// ----- rtl/mk3_merge.sv -----
// ----------------------------------------------------------------------------
// mk3_merge
// Combine both lane digests with their block words into the output register.
// ----------------------------------------------------------------------------
module mk3_merge (
  input  logic               clk,
  input  mk3_pkg::lane_ctl_t ctl,
  input  mk3_pkg::lane_out_t lane_a,
  input  mk3_pkg::lane_out_t lane_b,
  output logic [63:0]        plain_word_0,
  output logic [63:0]        plain_word_1,
  output logic [63:0]        plain_word_2,
  output logic [63:0]        plain_word_3
);
  import mk3_pkg::*;

  logic [63:0] pw0_r;
  logic [63:0] pw1_r;
  logic [63:0] pw2_r;
  logic [63:0] pw3_r;

  always_ff @(posedge clk) begin
    if (ctl.en[NUM_STAGES]) begin
      pw0_r <= lane_a.w0 ^ lane_a.h1;
      pw1_r <= lane_a.w1 ^ lane_a.h2;
      pw2_r <= lane_b.w0 ^ lane_b.h1;
      pw3_r <= lane_b.w1 ^ lane_b.h2;
    end
  end

  assign plain_word_0 = pw0_r;
  assign plain_word_1 = pw1_r;
  assign plain_word_2 = pw2_r;
  assign plain_word_3 = pw3_r;

endmodule
